### hw/rtl/sohpf_pkg.sv
// Shared types and constants of the second-order highpass filter.
package sohpf_pkg;

    // Configuration register file
    localparam int COEF_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FB11 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB12 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FB21 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FB22 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESET = 3'd7;

    localparam logic signed [COEF_W-1:0] CFG_RST [NUM_REGS] = '{
        32'sd8379, 32'sd762, -32'sd76168, -32'sd6855,
        32'sd167688, 32'sd762, 32'sd167772160, -32'sd167772
    };

    // Input commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRESET = 2'd2;

    // Multiplier operand A: codes below eight pick a config register
    localparam logic [3:0] ASEL_FB11   = 4'd0;
    localparam logic [3:0] ASEL_FB12   = 4'd1;
    localparam logic [3:0] ASEL_FB21   = 4'd2;
    localparam logic [3:0] ASEL_FB22   = 4'd3;
    localparam logic [3:0] ASEL_GAIN1  = 4'd4;
    localparam logic [3:0] ASEL_GAIN2  = 4'd5;
    localparam logic [3:0] ASEL_CUTOFF = 4'd6;
    localparam logic [3:0] ASEL_PRESET = 4'd7;
    localparam logic [3:0] ASEL_W2LO   = 4'd8;
    localparam logic [3:0] ASEL_W2HI   = 4'd9;

    // Multiplier operand B
    localparam logic [2:0] BSEL_S1LO = 3'd0;
    localparam logic [2:0] BSEL_S1HI = 3'd1;
    localparam logic [2:0] BSEL_S2LO = 3'd2;
    localparam logic [2:0] BSEL_S2HI = 3'd3;
    localparam logic [2:0] BSEL_N1LO = 3'd4;
    localparam logic [2:0] BSEL_N1HI = 3'd5;
    localparam logic [2:0] BSEL_SMP  = 3'd6;
    localparam logic [2:0] BSEL_CUT  = 3'd7;

    // Product alignment into the accumulator
    localparam logic [2:0] SH_ZERO = 3'd0;
    localparam logic [2:0] SH_32   = 3'd1;
    localparam logic [2:0] SH_64   = 3'd2;
    localparam logic [2:0] SH_F    = 3'd3;
    localparam logic [2:0] SH_F1   = 3'd4;
    localparam logic [2:0] SH_F33  = 3'd5;

    // Datapath widths
    localparam int MUL_W  = 33;
    localparam int PROD_W = 66;
    localparam int ACC_W  = 128;

    // Controller to datapath command
    typedef struct packed {
        logic       cap_in;
        logic       acc_clr;
        logic       acc_load;
        logic       mul_en;
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic [2:0] sh_sel;
        logic       neg;
        logic       to_w2;
        logic       cap_n1;
        logic       st_upd;
        logic       st_preset;
        logic       st_clr;
        logic       out_load;
    } t_dp_cmd;

endpackage

### hw/rtl/sohpf_dp.sv
// Datapath: config registers, shared multiply-accumulate, states and output register.
module sohpf_dp import sohpf_pkg::*; #(
    parameter int COEF_FRAC    = 24,
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [COEF_W-1:0]              i_cfg_data,
    input  t_dp_cmd                        i_dp_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered,
    output logic                           o_clipped
);

    localparam logic signed [STATE_WIDTH-1:0] ST_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0] ST_MIN = {1'b1, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic signed [COEF_W-1:0]       r_cfg [NUM_REGS];
    logic signed [SAMPLE_WIDTH-1:0] r_smp;
    logic signed [STATE_WIDTH-1:0]  r_s1;
    logic signed [STATE_WIDTH-1:0]  r_s2;
    logic signed [STATE_WIDTH-1:0]  r_n1;
    logic signed [63:0]             r_w2;
    logic signed [PROD_W-1:0]       r_prod;
    logic [2:0]                     r_p_sh;
    logic                           r_p_neg;
    logic                           r_p_w2;
    logic                           r_p_vld;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [SAMPLE_WIDTH-1:0] r_filtered;
    logic                           r_clipped;

    logic signed [63:0]             s1_x;
    logic signed [63:0]             s2_x;
    logic signed [63:0]             n1_x;
    logic signed [MUL_W-1:0]        a_op;
    logic signed [MUL_W-1:0]        b_op;
    logic signed [PROD_W-1:0]       prod;
    logic signed [ACC_W-1:0]        p_ext;
    logic signed [ACC_W-1:0]        p_sh;
    logic signed [ACC_W-1:0]        st_sh;
    logic [ACC_W-STATE_WIDTH:0]     st_hi;
    logic                           st_fit;
    logic signed [STATE_WIDTH-1:0]  st_sat;
    logic signed [ACC_W-1:0]        out_sh;
    logic [ACC_W-SAMPLE_WIDTH:0]    out_hi;
    logic                           out_fit;
    logic signed [SAMPLE_WIDTH-1:0] out_sat;

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_REGS; k++) begin
                r_cfg[k] <= CFG_RST[k];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Split states into 32-bit halves
    assign s1_x = 64'(r_s1);
    assign s2_x = 64'(r_s2);
    assign n1_x = 64'(r_n1);

    // Select operand A
    always_comb begin
        case (i_dp_cmd.a_sel)
            ASEL_W2LO: a_op = {1'b0, r_w2[31:0]};
            ASEL_W2HI: a_op = MUL_W'($signed(r_w2[63:32]));
            default:   a_op = MUL_W'(r_cfg[i_dp_cmd.a_sel[CFG_IDX_W-1:0]]);
        endcase
    end

    // Select operand B
    always_comb begin
        case (i_dp_cmd.b_sel)
            BSEL_S1LO: b_op = {1'b0, s1_x[31:0]};
            BSEL_S1HI: b_op = MUL_W'($signed(s1_x[63:32]));
            BSEL_S2LO: b_op = {1'b0, s2_x[31:0]};
            BSEL_S2HI: b_op = MUL_W'($signed(s2_x[63:32]));
            BSEL_N1LO: b_op = {1'b0, n1_x[31:0]};
            BSEL_N1HI: b_op = MUL_W'($signed(n1_x[63:32]));
            BSEL_SMP:  b_op = MUL_W'(r_smp);
            default:   b_op = MUL_W'(r_cfg[REG_CUTOFF]);
        endcase
    end

    assign prod = a_op * b_op;

    // Register the product with its alignment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= i_dp_cmd.mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= prod;
        r_p_sh  <= i_dp_cmd.sh_sel;
        r_p_neg <= i_dp_cmd.neg;
        r_p_w2  <= i_dp_cmd.to_w2;
    end

    // Align the registered product
    assign p_ext = ACC_W'(r_prod);

    always_comb begin
        case (r_p_sh)
            SH_32:   p_sh = p_ext <<< 32;
            SH_64:   p_sh = p_ext <<< 64;
            SH_F:    p_sh = p_ext <<< COEF_FRAC;
            SH_F1:   p_sh = p_ext <<< (COEF_FRAC + 1);
            SH_F33:  p_sh = p_ext <<< (COEF_FRAC + 33);
            default: p_sh = p_ext;
        endcase
    end

    // Accumulate
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_dp_cmd.acc_load) begin
            r_acc <= ACC_W'(r_smp) <<< (3 * COEF_FRAC);
        end else if (r_p_vld && !r_p_w2) begin
            r_acc <= r_p_neg ? (r_acc - p_sh) : (r_acc + p_sh);
        end
    end

    // Capture cutoff squared
    always_ff @(posedge i_clk) begin
        if (r_p_vld && r_p_w2) begin
            r_w2 <= r_prod[63:0];
        end
    end

    // Scale and saturate a new state value
    assign st_sh  = r_acc >>> COEF_FRAC;
    assign st_hi  = st_sh[ACC_W-1:STATE_WIDTH-1];
    assign st_fit = (&st_hi) | ~(|st_hi);
    assign st_sat = st_fit ? st_sh[STATE_WIDTH-1:0] : (r_acc[ACC_W-1] ? ST_MIN : ST_MAX);

    // Scale and saturate the output sample
    assign out_sh  = r_acc >>> (3 * COEF_FRAC);
    assign out_hi  = out_sh[ACC_W-1:SAMPLE_WIDTH-1];
    assign out_fit = (&out_hi) | ~(|out_hi);
    assign out_sat = out_fit ? out_sh[SAMPLE_WIDTH-1:0] : (r_acc[ACC_W-1] ? SMP_MIN : SMP_MAX);

    // Hold the sample of the current beat and capture new state one
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.cap_in) begin
            r_smp <= i_sample;
        end
        if (i_dp_cmd.cap_n1) begin
            r_n1 <= st_sat;
        end
    end

    // Update filter states
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (i_dp_cmd.st_clr) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (i_dp_cmd.st_preset) begin
            r_s1 <= st_sat;
            r_s2 <= '0;
        end else if (i_dp_cmd.st_upd) begin
            r_s1 <= r_n1;
            r_s2 <= st_sat;
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.out_load) begin
            r_filtered <= out_sat;
            r_clipped  <= ~out_fit;
        end
    end

    assign o_filtered = r_filtered;
    assign o_clipped  = r_clipped;

endmodule

### hw/rtl/sohpf_ctrl.sv
// Controller: handshakes and the multiply-accumulate sequence for each command.
module sohpf_ctrl import sohpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output t_dp_cmd          o_dp_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FILT = 2'd1;
    localparam logic [1:0] ST_PRE  = 2'd2;

    localparam logic [4:0] FILT_LAST = 5'd19;
    localparam logic [4:0] PRE_LAST  = 5'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic [4:0] r_step;
    logic [4:0] n_step;
    logic       r_out_vld;
    logic       n_out_vld;
    t_dp_cmd    filt_cmd;
    t_dp_cmd    pre_cmd;
    t_dp_cmd    dp_cmd;

    function automatic t_dp_cmd mul_op(input logic [3:0] a, input logic [2:0] b,
                                       input logic [2:0] sh, input logic neg);
        t_dp_cmd c;
        c        = '0;
        c.mul_en = 1'b1;
        c.a_sel  = a;
        c.b_sel  = b;
        c.sh_sel = sh;
        c.neg    = neg;
        return c;
    endfunction

    // Filter sequence: new state one, cutoff squared, new state two, then the output sum
    always_comb begin
        filt_cmd = '0;
        unique case (r_step)
            5'd0: begin
                filt_cmd         = mul_op(ASEL_FB11, BSEL_S1LO, SH_ZERO, 1'b0);
                filt_cmd.acc_clr = 1'b1;
            end
            5'd1: filt_cmd = mul_op(ASEL_FB11, BSEL_S1HI, SH_32, 1'b0);
            5'd2: filt_cmd = mul_op(ASEL_FB12, BSEL_S2LO, SH_ZERO, 1'b0);
            5'd3: filt_cmd = mul_op(ASEL_FB12, BSEL_S2HI, SH_32, 1'b0);
            5'd4: filt_cmd = mul_op(ASEL_GAIN1, BSEL_SMP, SH_F, 1'b0);
            5'd5: begin
                filt_cmd       = mul_op(ASEL_CUTOFF, BSEL_CUT, SH_ZERO, 1'b0);
                filt_cmd.to_w2 = 1'b1;
            end
            5'd6: begin
                filt_cmd         = mul_op(ASEL_FB21, BSEL_S1LO, SH_ZERO, 1'b0);
                filt_cmd.acc_clr = 1'b1;
                filt_cmd.cap_n1  = 1'b1;
            end
            5'd7:  filt_cmd = mul_op(ASEL_FB21, BSEL_S1HI, SH_32, 1'b0);
            5'd8:  filt_cmd = mul_op(ASEL_FB22, BSEL_S2LO, SH_ZERO, 1'b0);
            5'd9:  filt_cmd = mul_op(ASEL_FB22, BSEL_S2HI, SH_32, 1'b0);
            5'd10: filt_cmd = mul_op(ASEL_GAIN2, BSEL_SMP, SH_F, 1'b0);
            5'd12: begin
                filt_cmd          = mul_op(ASEL_W2LO, BSEL_N1LO, SH_ZERO, 1'b1);
                filt_cmd.st_upd   = 1'b1;
                filt_cmd.acc_load = 1'b1;
            end
            5'd13: filt_cmd = mul_op(ASEL_W2LO, BSEL_N1HI, SH_32, 1'b1);
            5'd14: filt_cmd = mul_op(ASEL_W2HI, BSEL_N1LO, SH_32, 1'b1);
            5'd15: filt_cmd = mul_op(ASEL_W2HI, BSEL_N1HI, SH_64, 1'b1);
            5'd16: filt_cmd = mul_op(ASEL_CUTOFF, BSEL_S2LO, SH_F1, 1'b1);
            5'd17: filt_cmd = mul_op(ASEL_CUTOFF, BSEL_S2HI, SH_F33, 1'b1);
            default: filt_cmd = '0;
        endcase
    end

    // Preset sequence: sample times preset gain into state one, state two cleared
    always_comb begin
        pre_cmd = '0;
        unique case (r_step)
            5'd0: begin
                pre_cmd         = mul_op(ASEL_PRESET, BSEL_SMP, SH_F, 1'b0);
                pre_cmd.acc_clr = 1'b1;
            end
            PRE_LAST: pre_cmd.st_preset = 1'b1;
            default:  pre_cmd = '0;
        endcase
    end

    // Next state
    always_comb begin
        dp_cmd    = '0;
        n_state   = r_state;
        n_step    = r_step;
        n_out_vld = r_out_vld & ~i_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    dp_cmd.cap_in = 1'b1;
                    n_step        = '0;
                    unique case (i_cmd)
                        CMD_FILTER: n_state = ST_FILT;
                        CMD_PRESET: n_state = ST_PRE;
                        CMD_CLEAR:  dp_cmd.st_clr = 1'b1;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_FILT: begin
                dp_cmd = filt_cmd;
                if (r_step == FILT_LAST) begin
                    // hold the result until the output slot frees up
                    if (!r_out_vld || i_ready) begin
                        dp_cmd.out_load = 1'b1;
                        n_out_vld       = 1'b1;
                        n_state         = ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            ST_PRE: begin
                dp_cmd = pre_cmd;
                if (r_step == PRE_LAST) begin
                    n_state = ST_IDLE;
                end else begin
                    n_step = r_step + 5'd1;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_vld;
    assign o_dp_cmd = dp_cmd;

endmodule

### hw/rtl/second_order_highpass_filter.sv
// Top level of the second-order state-space highpass filter.
//
// Input channel (i_valid/o_ready) carries one beat of i_cmd and i_sample.
// Filter beats produce one result beat on the output channel
// (o_valid/i_ready) with o_filtered and o_clipped; clear, preset and the
// unused command produce none.
// A filter or preset beat keeps o_ready low until its sequence ends; clear and
// the unused command leave the block idle. Filter work runs through the
// single shared 33x33 multiplier: 17 partial products plus pipeline drain.
// The output register parts the two channels: new beats are taken while a
// result waits. If a result is still waiting when the next one is done, the
// block holds in its last step until the receiver takes the old one.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) go straight into the
// config registers and are meant to be made only while the block is idle.
// Synchronous reset zeroes both states, drops any pending result and
// restores the default coefficients.
module second_order_highpass_filter import sohpf_pkg::*; #(
    parameter int COEF_FRAC    = 24,
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [CMD_W-1:0]               i_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_filtered,
    output logic                           o_clipped,
    input  logic                           i_cfg_we,
    input  logic [CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [COEF_W-1:0]              i_cfg_data
);

    t_dp_cmd dp_cmd;

    // Sequence the work
    sohpf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_cmd),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_dp_cmd (dp_cmd)
    );

    // Do the arithmetic
    sohpf_dp #(
        .COEF_FRAC    (COEF_FRAC),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STATE_WIDTH  (STATE_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_dp_cmd   (dp_cmd),
        .i_sample   (i_sample),
        .o_filtered (o_filtered),
        .o_clipped  (o_clipped)
    );

endmodule

### hw/rtl/sohpf_checker.sv
// Port-level checks of the highpass filter and their binding to the top level.
module sohpf_checker import sohpf_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic [CMD_W-1:0]        i_cmd,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [SAMPLE_WIDTH-1:0] o_filtered,
    input logic                    o_clipped
);

    localparam logic [SAMPLE_WIDTH-1:0] SMP_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_filtered) && $stable(o_clipped))
        else $error("result beat changed while stalled");

    // A clipped result sits at a bound
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |-> (o_filtered == SMP_MAX) || (o_filtered == SMP_MIN))
        else $error("clipped result not at a saturation bound");

    // A filter beat keeps the block busy
    a_filt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_cmd == CMD_FILTER) |=> !o_ready)
        else $error("ready right after a filter beat");

    // A new result appears only at the end of work
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while idle");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

endmodule

bind second_order_highpass_filter sohpf_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_sohpf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .i_cmd      (i_cmd),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_filtered (o_filtered),
    .o_clipped  (o_clipped)
);

### test/testbench.sv
// Self-checking testbench of the second-order highpass filter, with its predictor.
`timescale 1ns / 100ps

module testbench import sohpf_pkg::*; ();

    localparam int COEF_FRAC    = 24;
    localparam int SAMPLE_WIDTH = 16;
    localparam int STATE_WIDTH  = 48;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 30;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASE_ITEMS   = 125;
    localparam int NUM_PHASES    = 8;
    localparam int MAX_PRINTED   = 100;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] filtered;
        logic                           clipped;
    } t_output;

    // Predicts the filter outputs and holds those still to arrive
    class filter_tracker;
        logic signed [COEF_W-1:0]      coef [NUM_REGS];
        logic signed [STATE_WIDTH-1:0] st_one;
        logic signed [STATE_WIDTH-1:0] st_two;
        t_output                       pending_outputs [$];
        int                            errors;

        function new();
            for (int i = 0; i < NUM_REGS; i++) coef[i] = CFG_RST[i];
            st_one = '0;
            st_two = '0;
            errors = 0;
        endfunction

        task report(string what);
            if (errors < MAX_PRINTED) $display("mismatch: %s", what);
            errors++;
        endtask

        function void write_coef(int idx, logic [COEF_W-1:0] value);
            coef[idx] = value;
        endfunction

        function int pending();
            return pending_outputs.size();
        endfunction

        // Saturate to a signed value of the given width
        function logic signed [127:0] clamp(input logic signed [127:0] v, input int w,
                                            output logic hit);
            logic signed [127:0] top;
            logic signed [127:0] bottom;
            top    = (128'sd1 <<< (w - 1)) - 128'sd1;
            bottom = -top - 128'sd1;
            hit    = 1'b1;
            if (v > top) return top;
            if (v < bottom) return bottom;
            hit = 1'b0;
            return v;
        endfunction

        // Advance the state for one accepted input beat
        function void take_beat(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_WIDTH-1:0] smp);
            logic signed [127:0] sw, x1, x2, k11, k12, k21, k22, kg1, kg2, kw, kp;
            logic signed [127:0] acc, n1, n2, w2;
            logic                hit;
            t_output             res;
            sw  = 128'(smp);
            x1  = 128'(st_one);
            x2  = 128'(st_two);
            k11 = 128'(coef[REG_FB11]);
            k12 = 128'(coef[REG_FB12]);
            k21 = 128'(coef[REG_FB21]);
            k22 = 128'(coef[REG_FB22]);
            kg1 = 128'(coef[REG_GAIN1]);
            kg2 = 128'(coef[REG_GAIN2]);
            kw  = 128'(coef[REG_CUTOFF]);
            kp  = 128'(coef[REG_PRESET]);
            case (cmd)
                CMD_CLEAR: begin
                    st_one = '0;
                    st_two = '0;
                end
                CMD_PRESET: begin
                    st_one = STATE_WIDTH'(clamp(sw * kp, STATE_WIDTH, hit));
                    st_two = '0;
                end
                CMD_FILTER: begin
                    acc = k11 * x1 + k12 * x2 + ((kg1 * sw) <<< COEF_FRAC);
                    n1  = clamp(acc >>> COEF_FRAC, STATE_WIDTH, hit);
                    acc = k21 * x1 + k22 * x2 + ((kg2 * sw) <<< COEF_FRAC);
                    n2  = clamp(acc >>> COEF_FRAC, STATE_WIDTH, hit);
                    st_one = STATE_WIDTH'(n1);
                    st_two = STATE_WIDTH'(n2);
                    // Combine at three times the coefficient fraction
                    w2  = kw * kw;
                    acc = (sw <<< (3 * COEF_FRAC)) - w2 * n1
                        - ((kw * n2) <<< (COEF_FRAC + 1));
                    res.filtered = SAMPLE_WIDTH'(clamp(acc >>> (3 * COEF_FRAC),
                                                       SAMPLE_WIDTH, hit));
                    res.clipped  = hit;
                    pending_outputs.push_back(res);
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one accepted output beat with the oldest prediction
        task match_output(logic signed [SAMPLE_WIDTH-1:0] filtered, logic clipped);
            t_output want;
            if (pending_outputs.size() == 0) begin
                report($sformatf("output beat %0d/%0b with none predicted", filtered, clipped));
            end else begin
                want = pending_outputs.pop_front();
                if (filtered !== want.filtered)
                    report($sformatf("filtered %0d, predicted %0d", filtered, want.filtered));
                if (clipped !== want.clipped)
                    report($sformatf("clipped %0b, predicted %0b", clipped, want.clipped));
            end
        endtask
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_valid;
    logic                           o_ready;
    logic [CMD_W-1:0]               i_cmd;
    logic signed [SAMPLE_WIDTH-1:0] i_sample;
    logic                           o_valid;
    logic                           i_ready;
    logic signed [SAMPLE_WIDTH-1:0] o_filtered;
    logic                           o_clipped;
    logic                           i_cfg_we;
    logic [CFG_IDX_W-1:0]           i_cfg_idx;
    logic [COEF_W-1:0]              i_cfg_data;

    filter_tracker tracker;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            cycle_count;
    logic [COEF_W-1:0] coef_plan [NUM_REGS];

    second_order_highpass_filter #(
        .COEF_FRAC   (COEF_FRAC),
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .STATE_WIDTH (STATE_WIDTH)
    ) u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_cmd     (i_cmd),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_filtered(o_filtered),
        .o_clipped (o_clipped),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Stall the output side at random
    always @(negedge i_clk) begin
        i_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    // Check every accepted output beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) tracker.match_output(o_filtered, o_clipped);
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Send one input beat; enter and leave at a falling edge
    task send_beat(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_WIDTH-1:0] smp);
        int gap;
        gap = 0;
        while (gap < 12 && int'($urandom_range(99)) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_sample <= smp;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.take_beat(cmd, smp);
        @(negedge i_clk);
    endtask

    // Drop valid, drain all predicted outputs and let the block settle
    task wait_idle();
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the whole coefficient plan, one register per cycle
    task load_coefs();
        for (int i = 0; i < NUM_REGS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= coef_plan[i];
            tracker.write_coef(i, coef_plan[i]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Fill the coefficient plan for one phase
    task plan_coefs(int phase);
        int span;
        int base;
        for (int i = 0; i < NUM_REGS; i++) begin
            base = CFG_RST[i];
            case (phase)
                0, 5: begin
                    span = ((base < 0) ? -base : base) / 4 + 1;
                    coef_plan[i] = base + int'($urandom_range(2 * span)) - span;
                end
                1: coef_plan[i] = 32'h7FFF_FFFF;
                2: coef_plan[i] = 32'h8000_0000;
                3, 6: coef_plan[i] = $urandom;
                4: begin
                    case ($urandom_range(4))
                        0: coef_plan[i] = 32'h7FFF_FFFF;
                        1: coef_plan[i] = 32'h8000_0000;
                        2: coef_plan[i] = '0;
                        3: coef_plan[i] = 32'd1;
                        default: coef_plan[i] = '1;
                    endcase
                end
                default: coef_plan[i] = base;
            endcase
        end
    endtask

    // Pick a random sample, weighted toward the extremes and small values
    function logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(9))
            0: return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            2: return SAMPLE_WIDTH'(int'($urandom_range(16)) - 8);
            default: return r[SAMPLE_WIDTH-1:0];
        endcase
    endfunction

    initial begin
        int sent;
        int roll;
        logic [CMD_W-1:0] cmd;
        logic signed [SAMPLE_WIDTH-1:0] s_max;
        logic signed [SAMPLE_WIDTH-1:0] s_min;

        tracker        = new();
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ready        = 1'b0;
        i_cmd          = CMD_FILTER;
        i_sample       = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cycle_count    = 0;
        s_max = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        s_min = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

        // Hold reset, then release at a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed beats with the reset coefficients
        send_beat(CMD_FILTER, '0);
        send_beat(CMD_FILTER, s_max);
        send_beat(CMD_FILTER, s_max);
        send_beat(CMD_FILTER, s_max);
        send_beat(CMD_FILTER, s_min);
        send_beat(CMD_FILTER, s_min);
        send_beat(CMD_FILTER, 16'sd1);
        send_beat(CMD_FILTER, -16'sd1);
        send_beat(CMD_CLEAR, s_max);
        send_beat(CMD_FILTER, 16'sd100);
        send_beat(CMD_PRESET, s_max);
        send_beat(CMD_FILTER, s_max);
        send_beat(CMD_FILTER, s_max);
        send_beat(CMD_PRESET, s_min);
        send_beat(CMD_FILTER, s_min);
        send_beat(CMD_UNUSED, 16'sd1234);
        send_beat(CMD_FILTER, 16'sd0);
        send_beat(CMD_PRESET, 16'sd0);
        send_beat(CMD_CLEAR, 16'sd0);
        send_beat(CMD_FILTER, s_min);
        send_beat(CMD_PRESET, -16'sd7);
        send_beat(CMD_FILTER, 16'sd7);
        wait_idle();

        // Random phases, each with its own coefficients and idle pattern
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            plan_coefs(phase);
            load_coefs();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 78) cmd = CMD_FILTER;
                else if (roll < 87) cmd = CMD_PRESET;
                else if (roll < 94) cmd = CMD_CLEAR;
                else cmd = CMD_UNUSED;
                send_beat(cmd, pick_sample());
                if (cmd != CMD_UNUSED) sent++;
            end
            wait_idle();
        end

        // Any prediction left over is a missing output beat
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d predicted outputs never arrived", tracker.pending()));
        if (tracker.errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
